FILE: sv/source_text_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("source_text_tokenizer: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define STT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("source_text_tokenizer: next-cycle check failed");

`endif

FILE: sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types, constants and byte classing shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int MAX_NESTING = 16;
  localparam int DEPTH_W     = $clog2(MAX_NESTING + 1);
  localparam int STK_AW      = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  // Token classes
  localparam logic [3:0] CLS_UNKNOWN = 4'd0;
  localparam logic [3:0] CLS_IDENT   = 4'd1;
  localparam logic [3:0] CLS_NUMBER  = 4'd2;
  localparam logic [3:0] CLS_UTF8    = 4'd3;
  localparam logic [3:0] CLS_LINE    = 4'd4;
  localparam logic [3:0] CLS_SIGN    = 4'd5;
  localparam logic [3:0] CLS_SPACE   = 4'd6;
  localparam logic [3:0] CLS_QUOTE   = 4'd7;
  localparam logic [3:0] CLS_BRACKET = 4'd8;
  localparam logic [3:0] CLS_COMMENT = 4'd9;

  // Characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_CONT_LO = 8'h80;
  localparam logic [7:0] CH_LEAD_LO = 8'hC0;
  localparam logic [7:0] CH_LEAD3   = 8'hE0;
  localparam logic [7:0] CH_LEAD4   = 8'hF0;
  localparam logic [7:0] CH_LEAD_HI = 8'hF7;
  localparam logic [7:0] CH_DEL     = 8'h7F;

  typedef enum logic [4:0] {
    M_IDLE, M_IDENT, M_SIGN, M_SPACE, M_LINE, M_UTF, M_SLASH, M_LCOM,
    M_BCOM, M_QUOTE, M_BRACKET, M_ZERO, M_HEX0, M_HEX, M_INT, M_DOT,
    M_FRAC, M_EXPE, M_EXPM, M_EXP
  } mode_t;

  typedef enum logic [2:0] {
    I_NONE, I_SLASH, I_QUOTE, I_BCOM, I_LCOM
  } inner_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } stt_in_t;

  typedef struct packed {
    logic [3:0]  token_class;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic        depth_overflow;
    logic        final_token;
  } stt_out_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [3:0]  cls;
    logic        last;
    logic [31:0] pos;
  } stt_item_t;

  typedef struct packed {
    logic flushing;
    logic held;
  } stt_lex_st_t;

  function automatic logic [3:0] stt_class(input logic [7:0] b);
    logic [3:0] r;
    if (b == CH_TAB || b == CH_SPACE) r = CLS_SPACE;
    else if (b == CH_LF || b == CH_CR) r = CLS_LINE;
    else if (b == CH_DQUOTE || b == CH_SQUOTE) r = CLS_QUOTE;
    else if (b == CH_LPAREN || b == CH_LBRACK || b == CH_LBRACE) r = CLS_BRACKET;
    else if (b == CH_SLASH) r = CLS_COMMENT;
    else if (b >= "0" && b <= "9") r = CLS_NUMBER;
    else if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_") r = CLS_IDENT;
    else if (b >= CH_LEAD_LO && b <= CH_LEAD_HI) r = CLS_UTF8;
    else if (b > CH_SPACE && b < CH_DEL && b != CH_RPAREN && b != CH_RBRACK
             && b != CH_RBRACE) r = CLS_SIGN;
    else r = CLS_UNKNOWN;
    return r;
  endfunction

  function automatic logic stt_is_hex(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic [1:0] stt_closer_code(input logic [7:0] b);
    logic [1:0] r;
    if (b == CH_LPAREN) r = 2'd0;
    else if (b == CH_LBRACK) r = 2'd1;
    else r = 2'd2;
    return r;
  endfunction

  function automatic logic [7:0] stt_closer_char(input logic [1:0] code);
    logic [7:0] r;
    unique case (code)
      2'd1:    r = CH_RBRACK;
      2'd2:    r = CH_RBRACE;
      default: r = CH_RPAREN;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] stt_mode_cls(input mode_t m);
    logic [3:0] r;
    unique case (m)
      M_IDENT:                 r = CLS_IDENT;
      M_SIGN, M_SLASH:         r = CLS_SIGN;
      M_SPACE:                 r = CLS_SPACE;
      M_LINE:                  r = CLS_LINE;
      M_LCOM, M_BCOM:          r = CLS_COMMENT;
      M_QUOTE:                 r = CLS_QUOTE;
      M_BRACKET:               r = CLS_BRACKET;
      M_ZERO, M_HEX0, M_HEX, M_INT, M_DOT,
      M_FRAC, M_EXPE, M_EXPM, M_EXP: r = CLS_NUMBER;
      default:                 r = CLS_UNKNOWN;
    endcase
    return r;
  endfunction

  // Saturating length add
  function automatic logic [31:0] stt_grow(input logic [31:0] len, input logic [1:0] n);
    logic [32:0] s;
    s = {1'b0, len} + {31'b0, n};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

FILE: sv/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Input side: numbers each byte, classes it and queues it for the lexer.
// ----------------------------------------------------------------------------
module stt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  stt_pkg::stt_in_t   in_data,
  output logic               hd_valid,
  output stt_pkg::stt_item_t hd,
  input  logic               hd_pop
);
  import stt_pkg::*;

  stt_item_t   fifo_r [4];
  logic [1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        push, pop;

  assign in_stall = (cnt_r == 3'd4);
  assign push     = in_valid && !in_stall;
  assign hd_valid = (cnt_r != 3'd0);
  assign pop      = hd_pop && hd_valid;
  assign hd       = fifo_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 2'd1 : wp_r;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + {2'b0, push} - {2'b0, pop};
    // restart numbering after the final byte of a text
    pos_nxt = push ? (in_data.last_byte ? 32'd0 : pos_r + 32'd1) : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      pos_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= '{byte_value: in_data.byte_value,
                        cls:        stt_class(in_data.byte_value),
                        last:       in_data.last_byte,
                        pos:        pos_r};
    end
  end

endmodule

FILE: sv/stt_lex.sv
// ----------------------------------------------------------------------------
// stt_lex
// Lexer engine: one byte step per cycle while the output queue has room,
// replays held bytes on back-off, flushes open tokens at the end of a text.
// ----------------------------------------------------------------------------
module stt_lex (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 hd_valid,
  input  stt_pkg::stt_item_t   hd,
  output logic                 hd_pop,
  input  logic                 q_space,
  output logic                 push,
  output stt_pkg::stt_out_t    push_tok,
  output stt_pkg::stt_lex_st_t st
);
  import stt_pkg::*;

  mode_t        mode_r, mode_nxt;
  inner_t       inner_r, inner_nxt;
  logic [7:0]   pend_r [3];
  logic [7:0]   pend_nxt [3];
  logic [1:0]   pcnt_r, pcnt_nxt;
  logic [1:0]   stack_r [MAX_NESTING];
  logic         stk_we;
  logic [STK_AW-1:0] stk_wa;
  logic [1:0]   stk_wd;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [31:0]  start_r, start_nxt, len_r, len_nxt;
  logic         ovf_r, ovf_nxt;
  logic [7:0]   lead_r, lead_nxt, quote_r, quote_nxt;
  logic [1:0]   need_r, need_nxt;
  logic         esc_r, esc_nxt, star_r, star_nxt;
  logic [7:0]   rp_byte_r [3];
  logic [7:0]   rp_byte_nxt [3];
  logic [31:0]  rp_base_r, rp_base_nxt;
  logic [1:0]   rp_idx_r, rp_idx_nxt, rp_left_r, rp_left_nxt;
  logic         fl_r, fl_nxt;
  logic [31:0]  fl_pos_r, fl_pos_nxt;
  logic         p_valid_r, p_valid_nxt;
  stt_out_t     p_tok_r, p_tok_nxt;
  logic         emit_w, done_w;
  stt_out_t     tok_w;

  assign st = '{flushing: fl_r, held: p_valid_r};

  always_comb begin : lex_next
    logic [7:0]  b;
    logic [3:0]  c;
    logic [31:0] pos;
    logic        from_rp, go, feed, consume, closev, rel, do_start, last_step;
    logic [3:0]  ccls;
    logic [31:0] lenv;
    logic        ovfv;
    logic [DEPTH_W-1:0] d;
    logic [STK_AW-1:0]  d_m1;
    logic [1:0]  topc;
    logic        bskip;

    mode_nxt = mode_r;   inner_nxt = inner_r; pend_nxt = pend_r; pcnt_nxt = pcnt_r;
    depth_nxt = depth_r; start_nxt = start_r; len_nxt = len_r;   ovf_nxt = ovf_r;
    lead_nxt = lead_r;   quote_nxt = quote_r; need_nxt = need_r;
    esc_nxt = esc_r;     star_nxt = star_r;
    rp_byte_nxt = rp_byte_r; rp_base_nxt = rp_base_r;
    rp_idx_nxt = rp_idx_r;   rp_left_nxt = rp_left_r;
    fl_nxt = fl_r; fl_pos_nxt = fl_pos_r;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0;
    hd_pop = 1'b0; emit_w = 1'b0; done_w = 1'b0; tok_w = '0;

    from_rp   = (rp_left_r != 2'd0);
    b         = from_rp ? rp_byte_r[rp_idx_r] : hd.byte_value;
    c         = from_rp ? stt_class(b) : hd.cls;
    pos       = from_rp ? rp_base_r + {30'b0, rp_idx_r} : hd.pos;
    last_step = fl_r || (hd_valid && hd.last);
    go        = q_space && (from_rp || fl_r || hd_valid);
    feed      = from_rp || !fl_r;
    consume = 1'b0; closev = 1'b0; rel = 1'b0; do_start = 1'b0;
    ccls = CLS_UNKNOWN; lenv = len_r; ovfv = ovf_r; bskip = 1'b0;
    d = depth_r;
    d_m1 = STK_AW'(d - DEPTH_W'(1));
    topc = stack_r[d_m1];

    if (go && feed) begin
      unique case (mode_r)
        M_IDLE: do_start = 1'b1;
        M_IDENT: begin
          if (c == CLS_IDENT || c == CLS_NUMBER) begin
            lenv = stt_grow(len_r, 2'd1); consume = 1'b1;
          end else begin
            closev = 1'b1; ccls = CLS_IDENT; do_start = 1'b1;
          end
        end
        M_SIGN: begin
          if (c == CLS_SIGN) begin
            lenv = stt_grow(len_r, 2'd1); consume = 1'b1;
          end else begin
            closev = 1'b1; ccls = CLS_SIGN; do_start = 1'b1;
          end
        end
        M_SPACE: begin
          if (c == CLS_SPACE) begin
            lenv = stt_grow(len_r, 2'd1); consume = 1'b1;
          end else begin
            closev = 1'b1; ccls = CLS_SPACE; do_start = 1'b1;
          end
        end
        M_LINE: begin
          closev = 1'b1; ccls = CLS_LINE;
          if (c == CLS_LINE && b != lead_r) begin
            lenv = stt_grow(len_r, 2'd1); consume = 1'b1;
          end else begin
            do_start = 1'b1;
          end
        end
        M_UTF: begin
          if (b >= CH_CONT_LO && b < CH_LEAD_LO) begin
            consume = 1'b1;
            if ({1'b0, pcnt_r} + 3'd1 >= {1'b0, need_r}) begin
              lenv = stt_grow(len_r, pcnt_r + 2'd1); closev = 1'b1; ccls = CLS_UTF8;
            end else begin
              pend_nxt[pcnt_r] = b; pcnt_nxt = pcnt_r + 2'd1;
            end
          end else begin
            rel = 1'b1; ccls = CLS_UNKNOWN;
          end
        end
        M_SLASH: begin
          if (b == CH_STAR) begin
            lenv = stt_grow(len_r, 2'd1); star_nxt = 1'b0; mode_nxt = M_BCOM;
            consume = 1'b1;
          end else if (b == CH_SLASH) begin
            lenv = stt_grow(len_r, 2'd1); mode_nxt = M_LCOM; consume = 1'b1;
          end else if (c == CLS_SIGN) begin
            lenv = stt_grow(len_r, 2'd1); mode_nxt = M_SIGN; consume = 1'b1;
          end else begin
            closev = 1'b1; ccls = CLS_SIGN; do_start = 1'b1;
          end
        end
        M_LCOM: begin
          if (c == CLS_LINE) begin
            closev = 1'b1; ccls = CLS_COMMENT; do_start = 1'b1;
          end else begin
            lenv = stt_grow(len_r, 2'd1); consume = 1'b1;
          end
        end
        M_BCOM: begin
          lenv = stt_grow(len_r, 2'd1); consume = 1'b1;
          if (star_r && b == CH_SLASH) begin
            closev = 1'b1; ccls = CLS_COMMENT;
          end else begin
            star_nxt = (b == CH_STAR);
          end
        end
        M_QUOTE: begin
          if (esc_r) begin
            lenv = stt_grow(len_r, 2'd1); esc_nxt = 1'b0; consume = 1'b1;
          end else if (b == quote_r) begin
            lenv = stt_grow(len_r, 2'd1); closev = 1'b1; ccls = CLS_QUOTE; consume = 1'b1;
          end else if (b == CH_CR || b == CH_LF) begin
            closev = 1'b1; ccls = CLS_QUOTE; do_start = 1'b1;
          end else begin
            lenv = stt_grow(len_r, 2'd1); esc_nxt = (b == CH_BSLASH); consume = 1'b1;
          end
        end
        M_BRACKET: begin
          lenv = stt_grow(len_r, 2'd1); consume = 1'b1;
          unique case (inner_r)
            I_QUOTE: begin
              bskip = 1'b1;
              if (esc_r) esc_nxt = 1'b0;
              else if (b == quote_r || b == CH_CR || b == CH_LF) inner_nxt = I_NONE;
              else esc_nxt = (b == CH_BSLASH);
            end
            I_BCOM: begin
              bskip = 1'b1;
              if (star_r && b == CH_SLASH) inner_nxt = I_NONE;
              else star_nxt = (b == CH_STAR);
            end
            I_LCOM: begin
              bskip = 1'b1;
              if (c == CLS_LINE) inner_nxt = I_NONE;
            end
            I_SLASH: begin
              if (b == CH_STAR) begin
                bskip = 1'b1; inner_nxt = I_BCOM; star_nxt = 1'b0;
              end else if (b == CH_SLASH) begin
                bskip = 1'b1; inner_nxt = I_LCOM;
              end else begin
                inner_nxt = I_NONE;
              end
            end
            default: ;
          endcase
          if (!bskip) begin
            if (d >= DEPTH_W'(1) && d <= DEPTH_W'(MAX_NESTING)
                && b == stt_closer_char(topc)) begin
              depth_nxt = d - DEPTH_W'(1);
              if (d == DEPTH_W'(1)) begin
                closev = 1'b1; ccls = CLS_BRACKET;
              end
            end else if (c == CLS_QUOTE) begin
              inner_nxt = I_QUOTE; quote_nxt = b; esc_nxt = 1'b0;
            end else if (c == CLS_COMMENT) begin
              inner_nxt = I_SLASH;
            end else if (c == CLS_BRACKET) begin
              if (d < DEPTH_W'(MAX_NESTING)) begin
                stk_we = 1'b1; stk_wa = STK_AW'(d); stk_wd = stt_closer_code(b);
                depth_nxt = d + DEPTH_W'(1);
              end else begin
                ovfv = 1'b1;
              end
            end
          end
        end
        M_ZERO: begin
          if (b == "x" || b == "X") begin
            pend_nxt[pcnt_r] = b; pcnt_nxt = pcnt_r + 2'd1; mode_nxt = M_HEX0;
            consume = 1'b1;
          end else begin
            closev = 1'b1; ccls = CLS_NUMBER; do_start = 1'b1;
          end
        end
        M_HEX0: begin
          if (stt_is_hex(b)) begin
            lenv = stt_grow(len_r, 2'd2); pcnt_nxt = 2'd0; mode_nxt = M_HEX;
            consume = 1'b1;
          end else begin
            rel = 1'b1; ccls = CLS_NUMBER;
          end
        end
        M_HEX: begin
          if (stt_is_hex(b)) begin
            lenv = stt_grow(len_r, 2'd1); consume = 1'b1;
          end else begin
            closev = 1'b1; ccls = CLS_NUMBER; do_start = 1'b1;
          end
        end
        M_INT, M_FRAC: begin
          if (c == CLS_NUMBER) begin
            lenv = stt_grow(len_r, 2'd1); consume = 1'b1;
          end else if (b == CH_DOT && mode_r == M_INT) begin
            pend_nxt[pcnt_r] = b; pcnt_nxt = pcnt_r + 2'd1; mode_nxt = M_DOT;
            consume = 1'b1;
          end else if (b == "e" || b == "E") begin
            pend_nxt[pcnt_r] = b; pcnt_nxt = pcnt_r + 2'd1; mode_nxt = M_EXPE;
            consume = 1'b1;
          end else begin
            closev = 1'b1; ccls = CLS_NUMBER; do_start = 1'b1;
          end
        end
        M_DOT: begin
          if (c == CLS_NUMBER) begin
            lenv = stt_grow(len_r, 2'd2); pcnt_nxt = 2'd0; mode_nxt = M_FRAC;
            consume = 1'b1;
          end else begin
            rel = 1'b1; ccls = CLS_NUMBER;
          end
        end
        M_EXPE: begin
          if (b == CH_MINUS) begin
            pend_nxt[pcnt_r] = b; pcnt_nxt = pcnt_r + 2'd1; mode_nxt = M_EXPM;
            consume = 1'b1;
          end else if (c == CLS_NUMBER) begin
            lenv = stt_grow(len_r, pcnt_r + 2'd1); pcnt_nxt = 2'd0; mode_nxt = M_EXP;
            consume = 1'b1;
          end else begin
            rel = 1'b1; ccls = CLS_NUMBER;
          end
        end
        M_EXPM: begin
          if (c == CLS_NUMBER) begin
            lenv = stt_grow(len_r, 2'd3); pcnt_nxt = 2'd0; mode_nxt = M_EXP;
            consume = 1'b1;
          end else begin
            rel = 1'b1; ccls = CLS_NUMBER;
          end
        end
        M_EXP: begin
          if (c == CLS_NUMBER) begin
            lenv = stt_grow(len_r, 2'd1); consume = 1'b1;
          end else begin
            closev = 1'b1; ccls = CLS_NUMBER; do_start = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (go) begin
      // end of text: back off what is held, then close what is open
      pos = fl_pos_r;
      priority case (mode_r)
        M_UTF: begin
          rel = 1'b1; ccls = CLS_UNKNOWN;
        end
        M_HEX0, M_DOT, M_EXPE, M_EXPM: begin
          rel = 1'b1; ccls = CLS_NUMBER;
        end
        M_IDLE: done_w = 1'b1;
        default: begin
          closev = 1'b1; ccls = stt_mode_cls(mode_r);
        end
      endcase
    end

    len_nxt = lenv;
    ovf_nxt = ovfv;

    if (rel) begin
      rp_byte_nxt = pend_r;
      rp_left_nxt = pcnt_r;
      rp_idx_nxt  = 2'd0;
      rp_base_nxt = pos - {30'b0, pcnt_r};
    end

    if (closev || rel) begin
      emit_w = 1'b1;
      tok_w  = '{token_class: ccls, token_start: start_r, token_length: lenv,
                 depth_overflow: ovfv, final_token: 1'b0};
      mode_nxt = M_IDLE; pcnt_nxt = 2'd0; inner_nxt = I_NONE;
    end

    if (do_start) begin
      // an unknown byte after a close is not taken here and gets its own token from idle
      if (!(closev && c == CLS_UNKNOWN)) begin
        consume = 1'b1;
        start_nxt = pos; len_nxt = 32'd1; ovf_nxt = 1'b0; pcnt_nxt = 2'd0;
        unique case (c)
          CLS_IDENT:  mode_nxt = M_IDENT;
          CLS_NUMBER: mode_nxt = (b == "0") ? M_ZERO : M_INT;
          CLS_UTF8: begin
            lead_nxt = b;
            need_nxt = (b < CH_LEAD3) ? 2'd1 : ((b < CH_LEAD4) ? 2'd2 : 2'd3);
            mode_nxt = M_UTF;
          end
          CLS_LINE: begin
            lead_nxt = b; mode_nxt = M_LINE;
          end
          CLS_SIGN:  mode_nxt = M_SIGN;
          CLS_SPACE: mode_nxt = M_SPACE;
          CLS_QUOTE: begin
            quote_nxt = b; esc_nxt = 1'b0; mode_nxt = M_QUOTE;
          end
          CLS_BRACKET: begin
            depth_nxt = DEPTH_W'(1);
            stk_we = 1'b1; stk_wa = '0; stk_wd = stt_closer_code(b);
            inner_nxt = I_NONE; mode_nxt = M_BRACKET;
          end
          CLS_COMMENT: mode_nxt = M_SLASH;
          default: begin
            emit_w = 1'b1;
            tok_w  = '{token_class: CLS_UNKNOWN, token_start: pos, token_length: 32'd1,
                       depth_overflow: 1'b0, final_token: 1'b0};
          end
        endcase
      end
    end

    if (consume) begin
      if (from_rp) begin
        rp_idx_nxt  = rp_idx_r + 2'd1;
        rp_left_nxt = rp_left_r - 2'd1;
      end else begin
        hd_pop = 1'b1;
        if (hd.last) begin
          fl_nxt     = 1'b1;
          fl_pos_nxt = hd.pos + 32'd1;
        end
      end
    end

    // hold back the newest token of a final step so that it can carry the mark
    p_valid_nxt = p_valid_r;
    p_tok_nxt   = p_tok_r;
    if (emit_w && last_step) begin
      p_valid_nxt = 1'b1;
      p_tok_nxt   = tok_w;
    end
    if (done_w) begin
      p_valid_nxt = 1'b0;
      fl_nxt      = 1'b0;
      depth_nxt   = '0;
      ovf_nxt     = 1'b0;
      len_nxt     = '0;
    end
  end

  always_comb begin : lex_out
    push     = 1'b0;
    push_tok = tok_w;
    if (done_w) begin
      push     = p_valid_r;
      push_tok = p_tok_r;
      push_tok.final_token = 1'b1;
    end else if (emit_w && fl_r) begin
      push     = p_valid_r;
      push_tok = p_tok_r;
    end else if (emit_w && hd_valid && hd.last) begin
      push     = p_valid_r;
      push_tok = p_tok_r;
    end else if (emit_w) begin
      push     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      inner_r   <= I_NONE;
      pcnt_r    <= '0;
      depth_r   <= '0;
      start_r   <= '0;
      len_r     <= '0;
      ovf_r     <= 1'b0;
      esc_r     <= 1'b0;
      star_r    <= 1'b0;
      rp_idx_r  <= '0;
      rp_left_r <= '0;
      fl_r      <= 1'b0;
      p_valid_r <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      inner_r   <= inner_nxt;
      pcnt_r    <= pcnt_nxt;
      depth_r   <= depth_nxt;
      start_r   <= start_nxt;
      len_r     <= len_nxt;
      ovf_r     <= ovf_nxt;
      esc_r     <= esc_nxt;
      star_r    <= star_nxt;
      rp_idx_r  <= rp_idx_nxt;
      rp_left_r <= rp_left_nxt;
      fl_r      <= fl_nxt;
      p_valid_r <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r    <= pend_nxt;
    lead_r    <= lead_nxt;
    quote_r   <= quote_nxt;
    need_r    <= need_nxt;
    rp_byte_r <= rp_byte_nxt;
    rp_base_r <= rp_base_nxt;
    fl_pos_r  <= fl_pos_nxt;
    p_tok_r   <= p_tok_nxt;
    if (stk_we) begin
      stack_r[stk_wa] <= stk_wd;
    end
  end

endmodule

FILE: sv/stt_outq.sv
// ----------------------------------------------------------------------------
// stt_outq
// Two-entry result queue: parts the lexer from a stalling receiver.
// ----------------------------------------------------------------------------
module stt_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stt_pkg::stt_out_t push_tok,
  output logic              space,
  output logic              out_valid,
  input  logic              out_stall,
  output stt_pkg::stt_out_t out_data
);
  import stt_pkg::*;

  stt_out_t   q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop, wr;

  assign space     = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[rp_r];
  assign pop       = out_valid && !out_stall;
  assign wr        = push && space;

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= push_tok;
    end
  end

endmodule

FILE: sv/source_text_tokenizer.sv
// Source text tokenizer.
// in_valid/in_stall/in_data carry one byte of text and its last-byte mark;
// a byte is taken at a clock edge with in_valid high and in_stall low.
// out_valid/out_stall/out_data carry one token each: class, start offset,
// length, bracket overflow flag and a mark on the last token of a text.
// Bytes queue in a four-entry input buffer; the lexer steps one byte per
// cycle while the output queue has room, so a text inside tokens flows at
// one byte per cycle unless the receiver stalls. A token that ends on a
// byte that is itself an unknown or stray-closer token leaves that byte to
// a step of its own; a backed-off number or broken UTF-8 sequence first
// reports the accepted part, then replays each held byte (at most two) one
// per cycle while the queue has room; the end of a text closes the open
// token, then marks the final token. Each token passes the registered
// output queue to out_data. When the receiver stalls, the two-entry output
// queue and then the input buffer fill, and in_stall rises; nothing is lost.
// Reset (rst_n low, synchronous) empties both queues and returns the lexer
// to idle with the offset counter at zero; the offset also restarts at zero
// after every last byte.
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Top level: input buffer, lexer engine and output queue.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_defines.svh"

module source_text_tokenizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stt_pkg::stt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output stt_pkg::stt_out_t out_data
);
  import stt_pkg::*;

  logic        hd_valid, hd_pop, q_space, lx_push;
  stt_item_t   hd;
  stt_out_t    lx_tok;
  stt_lex_st_t lx_st;

  stt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .hd_valid (hd_valid),
    .hd       (hd),
    .hd_pop   (hd_pop)
  );

  stt_lex u_lex (
    .clk      (clk),
    .rst_n    (rst_n),
    .hd_valid (hd_valid),
    .hd       (hd),
    .hd_pop   (hd_pop),
    .q_space  (q_space),
    .push     (lx_push),
    .push_tok (lx_tok),
    .st       (lx_st)
  );

  stt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (lx_push),
    .push_tok  (lx_tok),
    .space     (q_space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `STT_ASSERT_IMPL(a_push_has_room, lx_push, q_space)
  `STT_ASSERT_IMPL(a_len_nonzero, out_valid, out_data.token_length != 32'd0)
  `STT_ASSERT_IMPL(a_ovf_only_bracket, out_valid && out_data.depth_overflow,
                   out_data.token_class == CLS_BRACKET)
  `STT_ASSERT_NEXT(a_final_ends_text, lx_push && lx_tok.final_token,
                   !lx_st.flushing && !lx_st.held)

endmodule

FILE: tb/source_text_tokenizer_checker.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_checker
// Watches both channels of the tokenizer. It predicts the tokens that each
// byte transfer closes and compares every token transfer, field by field,
// with the oldest prediction.
// ----------------------------------------------------------------------------
module source_text_tokenizer_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  stt_pkg::stt_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  stt_pkg::stt_out_t out_data,
  output int                fail_count,
  output int                tokens_pending,
  output int                tokens_checked
);
  import stt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH    = MAX_NESTING;
  localparam int MAX_PER_BYTE   = 4;

  stt_out_t    token_q[$];
  mode_t       lex_mode;
  inner_t      nest_inner;
  logic [7:0]  held_bytes[3];
  int          held_cnt;
  logic [1:0]  closer_stk[STACK_DEPTH];
  int          nest_depth;
  logic [31:0] offset;
  logic [31:0] tok_start;
  logic [31:0] tok_len;
  logic        tok_ovf;
  logic [7:0]  lead_b;
  int          utf_need;
  logic [7:0]  quote_b;
  logic        esc_on;
  logic        star_on;
  int          closed_now;

  function automatic logic [3:0] class_of(input logic [7:0] b);
    if (b == CH_TAB || b == CH_SPACE) return CLS_SPACE;
    if (b == CH_LF || b == CH_CR) return CLS_LINE;
    if (b == CH_DQUOTE || b == CH_SQUOTE) return CLS_QUOTE;
    if (b == CH_LPAREN || b == CH_LBRACK || b == CH_LBRACE) return CLS_BRACKET;
    if (b == CH_SLASH) return CLS_COMMENT;
    if (b >= 8'h30 && b <= 8'h39) return CLS_NUMBER;
    if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == 8'h5F)
      return CLS_IDENT;
    if (b >= CH_LEAD_LO && b <= CH_LEAD_HI) return CLS_UTF8;
    if (b >= 8'h21 && b <= 8'h7E && b != CH_RPAREN && b != CH_RBRACK && b != CH_RBRACE)
      return CLS_SIGN;
    return CLS_UNKNOWN;
  endfunction

  function automatic logic hex_digit(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [1:0] opener_code(input logic [7:0] b);
    return (b == CH_LPAREN) ? 2'd0 : ((b == CH_LBRACK) ? 2'd1 : 2'd2);
  endfunction

  function automatic logic [7:0] closer_of(input logic [1:0] code);
    return (code == 2'd1) ? CH_RBRACK : ((code == 2'd2) ? CH_RBRACE : CH_RPAREN);
  endfunction

  function automatic logic [3:0] class_of_mode(input mode_t m);
    case (m)
      M_IDENT:         return CLS_IDENT;
      M_SIGN, M_SLASH: return CLS_SIGN;
      M_SPACE:         return CLS_SPACE;
      M_LINE:          return CLS_LINE;
      M_LCOM, M_BCOM:  return CLS_COMMENT;
      M_QUOTE:         return CLS_QUOTE;
      M_BRACKET:       return CLS_BRACKET;
      M_IDLE, M_UTF:   return CLS_UNKNOWN;
      default:         return CLS_NUMBER;
    endcase
  endfunction

  task automatic lengthen(input int n);
    tok_len = (tok_len > 32'hFFFF_FFFF - n) ? 32'hFFFF_FFFF : tok_len + n;
  endtask

  task automatic hold(input logic [7:0] b);
    if (held_cnt < 3) begin
      held_bytes[held_cnt] = b;
      held_cnt++;
    end
  endtask

  task automatic emit_token(input logic [3:0] cls);
    stt_out_t t;
    if (closed_now < MAX_PER_BYTE) begin
      t.token_class    = cls;
      t.token_start    = tok_start;
      t.token_length   = tok_len;
      t.depth_overflow = tok_ovf;
      t.final_token    = 1'b0;
      token_q.push_back(t);
    end
    closed_now++;
    lex_mode   = M_IDLE;
    held_cnt   = 0;
    nest_inner = I_NONE;
  endtask

  task automatic clear_lexer();
    lex_mode   = M_IDLE;
    nest_inner = I_NONE;
    held_cnt   = 0;
    foreach (held_bytes[i]) held_bytes[i] = '0;
    foreach (closer_stk[i]) closer_stk[i] = '0;
    nest_depth = 0;
    offset     = '0;
    tok_start  = '0;
    tok_len    = '0;
    tok_ovf    = 1'b0;
    lead_b     = '0;
    utf_need   = 0;
    quote_b    = '0;
    esc_on     = 1'b0;
    star_on    = 1'b0;
  endtask

  // Report the accepted part, then lex the held bytes again
  task automatic back_off(input logic [3:0] cls, input logic [31:0] pos);
    logic [7:0] saved[3];
    int n;
    saved = held_bytes;
    n = held_cnt;
    emit_token(cls);
    for (int i = 0; i < n; i++) lex_byte(saved[i], pos - n + i);
  endtask

  task automatic open_token(input logic [7:0] b, input logic [31:0] pos);
    tok_start = pos;
    tok_len   = 1;
    tok_ovf   = 1'b0;
    held_cnt  = 0;
    case (class_of(b))
      CLS_IDENT:  lex_mode = M_IDENT;
      CLS_NUMBER: lex_mode = (b == 8'h30) ? M_ZERO : M_INT;
      CLS_UTF8: begin
        lead_b   = b;
        utf_need = (b < CH_LEAD3) ? 1 : ((b < CH_LEAD4) ? 2 : 3);
        lex_mode = M_UTF;
      end
      CLS_LINE: begin
        lead_b   = b;
        lex_mode = M_LINE;
      end
      CLS_SIGN:  lex_mode = M_SIGN;
      CLS_SPACE: lex_mode = M_SPACE;
      CLS_QUOTE: begin
        quote_b  = b;
        esc_on   = 1'b0;
        lex_mode = M_QUOTE;
      end
      CLS_BRACKET: begin
        nest_depth    = 1;
        closer_stk[0] = opener_code(b);
        nest_inner    = I_NONE;
        lex_mode      = M_BRACKET;
      end
      CLS_COMMENT: lex_mode = M_SLASH;
      default:     emit_token(CLS_UNKNOWN);
    endcase
  endtask

  task automatic bracket_step(input logic [7:0] b, input logic [3:0] c);
    int d;
    d = nest_depth;
    case (nest_inner)
      I_QUOTE: begin
        if (esc_on) esc_on = 1'b0;
        else if (b == quote_b || b == CH_CR || b == CH_LF) nest_inner = I_NONE;
        else esc_on = (b == CH_BSLASH);
        return;
      end
      I_BCOM: begin
        if (star_on && b == CH_SLASH) nest_inner = I_NONE;
        else star_on = (b == CH_STAR);
        return;
      end
      I_LCOM: begin
        if (c == CLS_LINE) nest_inner = I_NONE;
        return;
      end
      I_SLASH: begin
        if (b == CH_STAR) begin
          nest_inner = I_BCOM;
          star_on = 1'b0;
          return;
        end
        if (b == CH_SLASH) begin
          nest_inner = I_LCOM;
          return;
        end
        nest_inner = I_NONE;
      end
      default: ;
    endcase
    if (d >= 1 && d <= STACK_DEPTH && b == closer_of(closer_stk[d-1])) begin
      nest_depth = d - 1;
      if (nest_depth == 0) emit_token(CLS_BRACKET);
      return;
    end
    if (c == CLS_QUOTE) begin
      nest_inner = I_QUOTE;
      quote_b = b;
      esc_on = 1'b0;
    end else if (c == CLS_COMMENT) begin
      nest_inner = I_SLASH;
    end else if (c == CLS_BRACKET) begin
      if (d < STACK_DEPTH) begin
        closer_stk[nest_depth] = opener_code(b);
        nest_depth++;
      end else begin
        tok_ovf = 1'b1;
      end
    end
  endtask

  task automatic lex_byte(input logic [7:0] b, input logic [31:0] pos);
    logic [3:0] c;
    c = class_of(b);
    case (lex_mode)
      M_IDENT: begin
        if (c == CLS_IDENT || c == CLS_NUMBER) begin lengthen(1); return; end
        emit_token(CLS_IDENT);
      end
      M_SIGN: begin
        if (c == CLS_SIGN) begin lengthen(1); return; end
        emit_token(CLS_SIGN);
      end
      M_SPACE: begin
        if (c == CLS_SPACE) begin lengthen(1); return; end
        emit_token(CLS_SPACE);
      end
      M_LINE: begin
        if (c == CLS_LINE && b != lead_b) begin
          lengthen(1);
          emit_token(CLS_LINE);
          return;
        end
        emit_token(CLS_LINE);
      end
      M_UTF: begin
        if (b >= CH_CONT_LO && b < CH_LEAD_LO) begin
          if (held_cnt + 1 >= utf_need) begin
            lengthen(held_cnt + 1);
            emit_token(CLS_UTF8);
          end else begin
            hold(b);
          end
          return;
        end
        back_off(CLS_UNKNOWN, pos);
        lex_byte(b, pos);
        return;
      end
      M_SLASH: begin
        if (b == CH_STAR) begin
          lengthen(1);
          star_on = 1'b0;
          lex_mode = M_BCOM;
          return;
        end
        if (b == CH_SLASH) begin
          lengthen(1);
          lex_mode = M_LCOM;
          return;
        end
        lex_mode = M_SIGN;
        if (c == CLS_SIGN) begin lengthen(1); return; end
        emit_token(CLS_SIGN);
      end
      M_LCOM: begin
        if (c != CLS_LINE) begin lengthen(1); return; end
        emit_token(CLS_COMMENT);
      end
      M_BCOM: begin
        lengthen(1);
        if (star_on && b == CH_SLASH) emit_token(CLS_COMMENT);
        else star_on = (b == CH_STAR);
        return;
      end
      M_QUOTE: begin
        if (esc_on) begin
          lengthen(1);
          esc_on = 1'b0;
          return;
        end
        if (b == quote_b) begin
          lengthen(1);
          emit_token(CLS_QUOTE);
          return;
        end
        if (b != CH_CR && b != CH_LF) begin
          lengthen(1);
          esc_on = (b == CH_BSLASH);
          return;
        end
        emit_token(CLS_QUOTE);
      end
      M_BRACKET: begin
        lengthen(1);
        bracket_step(b, c);
        return;
      end
      M_ZERO: begin
        if (b == 8'h78 || b == 8'h58) begin
          hold(b);
          lex_mode = M_HEX0;
          return;
        end
        emit_token(CLS_NUMBER);
      end
      M_HEX0: begin
        if (hex_digit(b)) begin
          lengthen(2);
          held_cnt = 0;
          lex_mode = M_HEX;
          return;
        end
        back_off(CLS_NUMBER, pos);
        lex_byte(b, pos);
        return;
      end
      M_HEX: begin
        if (hex_digit(b)) begin lengthen(1); return; end
        emit_token(CLS_NUMBER);
      end
      M_INT, M_FRAC: begin
        if (c == CLS_NUMBER) begin lengthen(1); return; end
        if (b == CH_DOT && lex_mode == M_INT) begin
          hold(b);
          lex_mode = M_DOT;
          return;
        end
        if (b == 8'h65 || b == 8'h45) begin
          hold(b);
          lex_mode = M_EXPE;
          return;
        end
        emit_token(CLS_NUMBER);
      end
      M_DOT: begin
        if (c == CLS_NUMBER) begin
          lengthen(2);
          held_cnt = 0;
          lex_mode = M_FRAC;
          return;
        end
        back_off(CLS_NUMBER, pos);
        lex_byte(b, pos);
        return;
      end
      M_EXPE: begin
        if (b == CH_MINUS) begin
          hold(b);
          lex_mode = M_EXPM;
          return;
        end
        if (c == CLS_NUMBER) begin
          lengthen(held_cnt + 1);
          held_cnt = 0;
          lex_mode = M_EXP;
          return;
        end
        back_off(CLS_NUMBER, pos);
        lex_byte(b, pos);
        return;
      end
      M_EXPM: begin
        if (c == CLS_NUMBER) begin
          lengthen(3);
          held_cnt = 0;
          lex_mode = M_EXP;
          return;
        end
        back_off(CLS_NUMBER, pos);
        lex_byte(b, pos);
        return;
      end
      M_EXP: begin
        if (c == CLS_NUMBER) begin lengthen(1); return; end
        emit_token(CLS_NUMBER);
      end
      default: ;
    endcase
    open_token(b, pos);
  endtask

  task automatic predict_byte(input stt_in_t item);
    logic [31:0] pos;
    pos = offset;
    closed_now = 0;
    lex_byte(item.byte_value, pos);
    offset = pos + 1;
    if (item.last_byte) begin
      if (lex_mode == M_UTF) back_off(CLS_UNKNOWN, offset);
      else if (lex_mode inside {M_HEX0, M_DOT, M_EXPE, M_EXPM})
        back_off(CLS_NUMBER, offset);
      if (lex_mode != M_IDLE) emit_token(class_of_mode(lex_mode));
      if (closed_now > 0) token_q[token_q.size()-1].final_token = 1'b1;
      clear_lexer();
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: token mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
             want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    stt_out_t want;
    if (!rst_n) begin
      clear_lexer();
      token_q.delete();
      fail_count = 0;
      tokens_checked = 0;
    end else begin
      if (in_valid && !in_stall) predict_byte(in_data);
      if (out_valid && !out_stall) begin
        tokens_checked++;
        if (token_q.size() == 0) begin
          report("unexpected token", out_data.token_start, 32'd0);
        end else begin
          want = token_q.pop_front();
          if (out_data.token_class != want.token_class)
            report("class", 32'(out_data.token_class), 32'(want.token_class));
          if (out_data.token_start != want.token_start)
            report("start", out_data.token_start, want.token_start);
          if (out_data.token_length != want.token_length)
            report("length", out_data.token_length, want.token_length);
          if (out_data.depth_overflow != want.depth_overflow)
            report("depth_overflow", 32'(out_data.depth_overflow),
                   32'(want.depth_overflow));
          if (out_data.final_token != want.final_token)
            report("final_token", 32'(out_data.final_token), 32'(want.final_token));
        end
      end
    end
    tokens_pending <= token_q.size();
  end

endmodule

FILE: tb/source_text_tokenizer_test.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_test
// Drives texts into the tokenizer: a directed set of corner cases, then
// random texts built from tokens, some cut short, with noise mixed in, under
// random gaps and receiver stalls outside a calm stretch. The checker judges every token.
// ----------------------------------------------------------------------------
module source_text_tokenizer_test;
  import stt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 450;
  localparam int STALL_LIMIT  = 5000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  stt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  stt_out_t out_data;

  int   fail_count;
  int   tokens_pending;
  int   tokens_checked;
  int   bytes_sent = 0;
  int   texts_sent = 0;
  int   quiet_cycles = 0;
  bit   calm = 1'b0;
  logic [7:0] text_q[$];

  always #5 clk = ~clk;

  source_text_tokenizer u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  source_text_tokenizer_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .tokens_pending, .tokens_checked
  );

  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 37);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold valid between back-to-back bytes; drop it only while idling
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{byte_value: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (last) texts_sent++;
  endtask

  // Send the queued text, marking its final byte
  task automatic send_text();
    logic [7:0] b;
    while (text_q.size() > 0) begin
      b = text_q.pop_front();
      send_byte(b, text_q.size() == 0);
    end
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic add_random_token();
    int n;
    logic [7:0] qb;
    case ($urandom_range(13))
      0: begin
        add_str("_");
        repeat ($urandom_range(4)) text_q.push_back(8'(8'h61 + $urandom_range(25)));
        text_q.push_back(8'(8'h30 + $urandom_range(9)));
      end
      1: begin
        add_str($urandom_range(1) ? "0x" : "0X");
        repeat ($urandom_range(3)) text_q.push_back(pick("3Fa"));
      end
      2: begin
        repeat (1 + $urandom_range(2)) text_q.push_back(8'(8'h31 + $urandom_range(8)));
        if ($urandom_range(1)) begin
          add_str(".");
          repeat ($urandom_range(2)) text_q.push_back(8'(8'h30 + $urandom_range(9)));
        end
        if ($urandom_range(1)) begin
          add_str($urandom_range(1) ? "e" : "E");
          if ($urandom_range(1)) add_str("-");
          repeat ($urandom_range(2)) text_q.push_back(8'(8'h30 + $urandom_range(9)));
        end
      end
      3: begin
        n = $urandom_range(3);
        text_q.push_back(n == 0 ? 8'(8'hC0 + $urandom_range(31)) :
                         n == 1 ? 8'(8'hE0 + $urandom_range(15)) :
                                  8'(8'hF0 + $urandom_range(7)));
        repeat ($urandom_range(3)) text_q.push_back(8'(8'h80 + $urandom_range(63)));
      end
      4: repeat (1 + $urandom_range(1)) text_q.push_back($urandom_range(1) ? CH_CR : CH_LF);
      5: repeat (1 + $urandom_range(3)) text_q.push_back(pick("+-*=<.!#"));
      6: repeat (1 + $urandom_range(3)) text_q.push_back($urandom_range(1) ? CH_TAB : CH_SPACE);
      7: begin
        qb = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        text_q.push_back(qb);
        repeat ($urandom_range(5)) text_q.push_back(pick("a\\\"'\n "));
        if ($urandom_range(3) != 0) text_q.push_back(qb);
      end
      8: begin
        add_str($urandom_range(1) ? "/*" : "//");
        repeat ($urandom_range(5)) text_q.push_back(pick("ab*/\r "));
        if ($urandom_range(1)) add_str("*/");
      end
      9, 10: begin
        n = ($urandom_range(9) == 0) ? 14 + $urandom_range(5) : $urandom_range(4);
        repeat (n) text_q.push_back(pick("([{"));
        repeat ($urandom_range(4)) text_q.push_back(pick("a\"/*)]}'x"));
        repeat (n + $urandom_range(1)) text_q.push_back(pick(")]}"));
      end
      default: text_q.push_back(8'($urandom_range(255)));
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases
    add_str("0x1F 1.5e-3 0xg 1.x 9e-z");
    send_text();
    text_q = '{8'hC3, 8'hA9, 8'hE2, 8'h41, CH_CR, CH_LF, CH_LF, CH_CR, CH_CR, CH_CR,
               8'hFF, 8'h00, CH_RPAREN};
    send_text();
    add_str("\"a\\\"b\" 'q\n/*c*/ //d\r/+");
    send_text();
    add_str("(a[\"]\"/*)*/]{}) ");
    send_text();
    repeat (17) add_str("(");
    add_str("[)");
    send_text();
    add_str("0x");
    send_text();
    add_str("7e-");
    send_text();
    add_str("0");
    send_text();
    send_byte(8'hF4, 1'b1);

    // Let every token drain before the random texts
    in_valid <= 1'b0;
    @(posedge clk);
    wait (tokens_pending == 0);
    repeat (5) @(posedge clk);

    while (bytes_sent < RANDOM_BYTES) begin
      calm = (bytes_sent > 250 && bytes_sent < 350);
      repeat (1 + $urandom_range(8)) add_random_token();
      send_text();
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    wait (tokens_pending == 0);
    repeat (30) @(posedge clk);
    $display("Sent %0d bytes in %0d texts; %0d tokens compared.", bytes_sent, texts_sent,
             tokens_checked);
    if (fail_count == 0 && tokens_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
